// ===== hdl/vrra_pkg.sv =====
package vrra_pkg;

	localparam int BUF_BYTES_DEF = 4096;
	localparam int CFG_RST       = 4096;
	localparam int TAG_BYTES     = 4;

	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_PEEK  = 2'd1;
	localparam logic [1:0] REQ_POP   = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_SPACE = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;

	typedef enum logic [1:0] {
		OP_ALLOC,
		OP_PEEK,
		OP_POP,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [11:0] len;
		logic [12:0] rec_bytes;
	} entry_t;

	// tag plus payload, rounded up to whole words
	function automatic logic [12:0] record_bytes(input logic [11:0] len);
		logic [13:0] s;
		begin
			s = 14'(len) + 14'(TAG_BYTES + 3);
			return {s[12:2], 2'b00};
		end
	endfunction

endpackage

// ===== hdl/variable_record_ring_allocator.sv =====
// Flow: an allocate, or a peek or pop that finds the ring empty, goes from the queue head
// into the output register; any other peek or pop first reads the tag memory in S_READ.
// Throughput: one allocate per cycle unless the output stalls; a peek or pop waits in
// S_READ for the tag read before a pop moves the head; a 2-word queue sits in front.
// Reset: head, tail and wrap top clear to 0 and the ring size returns to 4096 bytes
// (clamped to BUF_BYTES); the tag memory is not cleared and no sweep runs.
module variable_record_ring_allocator #(
	parameter int BUF_BYTES = vrra_pkg::BUF_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [12:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [11:0] alloc_len,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [12:0] record_offset,
	output logic [11:0] record_len
);

	logic             q_valid;
	logic             q_pop;
	vrra_pkg::entry_t q_entry;

	vrra_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.alloc_len(alloc_len),
		.q_valid  (q_valid),
		.q_entry  (q_entry),
		.q_pop    (q_pop)
	);

	vrra_back #(
		.BUF_BYTES(BUF_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.q_valid      (q_valid),
		.q_entry      (q_entry),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.record_offset(record_offset),
		.record_len   (record_len)
	);

endmodule

// ===== hdl/vrra_ram.sv =====
module vrra_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/vrra_front.sv =====
module vrra_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       req_type,
	input  logic [11:0]      alloc_len,
	output logic             q_valid,
	output vrra_pkg::entry_t q_entry,
	input  logic             q_pop
);

	vrra_pkg::entry_t fifo_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	vrra_pkg::entry_t new_entry;
	logic             push;

	always_comb begin
		new_entry.len       = alloc_len;
		new_entry.rec_bytes = vrra_pkg::record_bytes(alloc_len);
		unique case (req_type)
			vrra_pkg::REQ_ALLOC: new_entry.op = vrra_pkg::OP_ALLOC;
			vrra_pkg::REQ_PEEK:  new_entry.op = vrra_pkg::OP_PEEK;
			vrra_pkg::REQ_POP:   new_entry.op = vrra_pkg::OP_POP;
			default:             new_entry.op = vrra_pkg::OP_NOP;
		endcase
	end

	assign in_stall = count_q[1];
	assign push     = in_valid && !in_stall;
	assign q_valid  = count_q != 2'd0;
	assign q_entry  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 2'd1;
			end else if (q_pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ===== hdl/vrra_back.sv =====
module vrra_back #(
	parameter int BUF_BYTES = vrra_pkg::BUF_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [12:0]      cfg_wr_data,
	input  logic             q_valid,
	input  vrra_pkg::entry_t q_entry,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       status,
	output logic [12:0]      record_offset,
	output logic [11:0]      record_len
);

	localparam int TAG_DEPTH = BUF_BYTES / 4;
	localparam int IDX_W     = $clog2(TAG_DEPTH);
	localparam int RST_CLAMP = (vrra_pkg::CFG_RST > BUF_BYTES) ? BUF_BYTES : vrra_pkg::CFG_RST;
	localparam int RST_RING  = (RST_CLAMP / 4) * 4;

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	function automatic logic [IDX_W-1:0] word_idx(input logic [12:0] p);
		logic [31:0] w;
		begin
			w = 32'(p[12:2]);
			return w[IDX_W-1:0];
		end
	endfunction

	function automatic logic word_in_range(input logic [12:0] p);
		return 32'(p[12:2]) < 32'(TAG_DEPTH);
	endfunction

	state_t      state_q;
	logic [12:0] ring_q;
	logic [12:0] head_q;
	logic [12:0] tail_q;
	logic [12:0] wrap_q;
	logic        pop_q;
	logic        rd_ok_q;
	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [12:0] offset_q;
	logic [11:0] len_q;

	logic [31:0]      cfg_clamp;
	logic [12:0]      ring_next;
	logic             slot_free;
	logic             start;
	logic             finish;
	logic             emit;
	logic [12:0]      head_w;
	logic             unwrapped;
	logic signed [14:0] head_s;
	logic signed [14:0] tail_s;
	logic signed [14:0] adj_s;
	logic signed [14:0] upper_s;
	logic             fit_tail;
	logic             fit_wrap;
	logic             is_read;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic             ram_re;
	logic [11:0]      ram_rdata;
	logic [11:0]      rd_len;

	always_comb begin
		cfg_clamp = (32'(cfg_wr_data) > 32'(BUF_BYTES)) ? 32'(BUF_BYTES) : 32'(cfg_wr_data);
		ring_next = {cfg_clamp[12:2], 2'b00};

		slot_free = !out_valid_q || !out_stall;
		start     = (state_q == S_IDLE) && q_valid && slot_free;
		finish    = (state_q == S_READ) && slot_free;
		q_pop     = start;

		head_w = ((head_q > tail_q) && (head_q >= wrap_q)) ? 13'd0 : head_q;

		unwrapped = head_q <= tail_q;
		head_s    = $signed({2'b00, head_q});
		tail_s    = $signed({2'b00, tail_q});
		adj_s     = $signed({2'b00, q_entry.rec_bytes});
		upper_s   = unwrapped ? $signed({2'b00, ring_q}) : head_s - 15'sd1;
		fit_tail  = (upper_s - tail_s) >= adj_s;
		fit_wrap  = unwrapped && ((head_s - 15'sd1) >= adj_s);

		is_read = (q_entry.op == vrra_pkg::OP_PEEK) || (q_entry.op == vrra_pkg::OP_POP);

		emit = (start && !(is_read && (head_w != tail_q))) || finish;

		ram_waddr = fit_tail ? word_idx(tail_q) : '0;
		ram_we    = start && (q_entry.op == vrra_pkg::OP_ALLOC) && (fit_tail || fit_wrap)
			&& (fit_tail ? word_in_range(tail_q) : 1'b1);
		ram_re    = start && is_read && (head_w != tail_q);

		rd_len = rd_ok_q ? ram_rdata : 12'd0;
	end

	vrra_ram #(
		.WIDTH(12),
		.DEPTH(TAG_DEPTH)
	) u_tags (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(q_entry.len),
		.re   (ram_re),
		.raddr(word_idx(head_w)),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ring_q      <= 13'(RST_RING);
			head_q      <= 13'd0;
			tail_q      <= 13'd0;
			wrap_q      <= 13'd0;
			pop_q       <= 1'b0;
			rd_ok_q     <= 1'b0;
			out_valid_q <= 1'b0;
			status_q    <= vrra_pkg::ST_OK;
			offset_q    <= 13'd0;
			len_q       <= 12'd0;
		end else begin
			if (cfg_wr_en) begin
				ring_q <= ring_next;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						unique case (q_entry.op)
							vrra_pkg::OP_ALLOC: begin
								len_q <= 12'd0;
								if (fit_tail) begin
									status_q <= vrra_pkg::ST_OK;
									offset_q <= tail_q + 13'(vrra_pkg::TAG_BYTES);
									tail_q   <= 13'(tail_s + adj_s);
								end else if (fit_wrap) begin
									status_q <= vrra_pkg::ST_OK;
									offset_q <= 13'(vrra_pkg::TAG_BYTES);
									wrap_q   <= tail_q;
									tail_q   <= q_entry.rec_bytes;
								end else begin
									status_q <= vrra_pkg::ST_NO_SPACE;
									offset_q <= 13'd0;
								end
							end
							vrra_pkg::OP_PEEK, vrra_pkg::OP_POP: begin
								head_q <= head_w;
								if (head_w == tail_q) begin
									status_q <= vrra_pkg::ST_EMPTY;
									offset_q <= 13'd0;
									len_q    <= 12'd0;
								end else begin
									pop_q   <= q_entry.op == vrra_pkg::OP_POP;
									rd_ok_q <= word_in_range(head_w);
									state_q <= S_READ;
								end
							end
							default: begin
								status_q <= vrra_pkg::ST_OK;
								offset_q <= 13'd0;
								len_q    <= 12'd0;
							end
						endcase
					end
				end
				S_READ: begin
					if (finish) begin
						status_q <= vrra_pkg::ST_OK;
						offset_q <= head_q + 13'(vrra_pkg::TAG_BYTES);
						len_q    <= rd_len;
						if (pop_q) begin
							head_q <= head_q + vrra_pkg::record_bytes(rd_len);
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign record_offset = offset_q;
	assign record_len    = len_q;

endmodule
